FILE: hdl/differential_heater_relay_control_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the differential heater relay controller
// Short forms for clocked concurrent assertions on clk / rst.
// ---------------------------------------------------------------------------
`ifndef DIFFERENTIAL_HEATER_RELAY_CONTROL_DEFINES_SVH
`define DIFFERENTIAL_HEATER_RELAY_CONTROL_DEFINES_SVH

// Checked on every edge outside reset
`define HDRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define HDRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/hdrc_pkg.sv
// ---------------------------------------------------------------------------
// hdrc_pkg
// Widths, register codes, reset values and item types of the relay controller.
// ---------------------------------------------------------------------------
package hdrc_pkg;

  localparam int TEMP_W     = 12;  // signed temperature, 1/16 C
  localparam int HYST_W     = 11;  // unsigned hysteresis
  localparam int CALC_W     = 14;  // holds temp + hyst and diff + hyst exactly
  localparam int ERR_CNT_W  = 6;
  localparam int LIMIT_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int S_TDATA_W  = 24;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 8;
  localparam int M_TUSER_W  = 2;

  localparam logic [LIMIT_W-1:0]   ERROR_LIMIT_DEF = 8'd60;
  localparam logic [ERR_CNT_W-1:0] ERR_CNT_MAX     = '1;

  // Register codes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIPE_LIMIT         = 3'd0,
    REG_BOILER_UPPER_LIMIT = 3'd1,
    REG_BOILER_UPPER_HYST  = 3'd2,
    REG_BOILER_SETPOINT    = 3'd3,
    REG_DIFF_HYST          = 3'd4,
    REG_DIFF_THRESHOLD     = 3'd5,
    REG_INSTANT_SETPOINT   = 3'd6,
    REG_INSTANT_HYST       = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] PIPE_LIMIT_RST         = 12'sd1440;
  localparam logic signed [TEMP_W-1:0] BOILER_UPPER_LIMIT_RST = 12'sd1440;
  localparam logic        [HYST_W-1:0] BOILER_UPPER_HYST_RST  = 11'd80;
  localparam logic signed [TEMP_W-1:0] BOILER_SETPOINT_RST    = 12'sd960;
  localparam logic        [HYST_W-1:0] DIFF_HYST_RST          = 11'd32;
  localparam logic signed [TEMP_W-1:0] DIFF_THRESHOLD_RST     = 12'sd160;
  localparam logic signed [TEMP_W-1:0] INSTANT_SETPOINT_RST   = 12'sd720;
  localparam logic        [HYST_W-1:0] INSTANT_HYST_RST       = 11'd32;

  typedef struct packed {
    logic signed [TEMP_W-1:0] pipe_limit;
    logic signed [TEMP_W-1:0] boiler_upper_limit;
    logic        [HYST_W-1:0] boiler_upper_hyst;
    logic signed [TEMP_W-1:0] boiler_setpoint;
    logic        [HYST_W-1:0] diff_hyst;
    logic signed [TEMP_W-1:0] diff_threshold;
    logic signed [TEMP_W-1:0] instant_setpoint;
    logic        [HYST_W-1:0] instant_hyst;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] boiler_temp;
    logic                     boiler_ok;
    logic signed [TEMP_W-1:0] pipe_temp;
    logic                     pipe_ok;
  } item_t;

  typedef struct packed {
    logic                 boiler_on;
    logic                 instant_on;
    logic [ERR_CNT_W-1:0] error_count;
  } state_t;

  typedef struct packed {
    logic boiler_heat;
    logic instant_heat;
    logic reading_valid;
    logic reset_request;
  } result_t;

endpackage

FILE: hdl/hdrc_cfg_regs.sv
// ---------------------------------------------------------------------------
// hdrc_cfg_regs
// Limit, setpoint, threshold and hysteresis registers behind the plain write port.
// ---------------------------------------------------------------------------
module hdrc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hdrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output hdrc_pkg::cfg_t                   cfg
);
  import hdrc_pkg::*;

  // Register file, one register per write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pipe_limit         <= PIPE_LIMIT_RST;
      cfg.boiler_upper_limit <= BOILER_UPPER_LIMIT_RST;
      cfg.boiler_upper_hyst  <= BOILER_UPPER_HYST_RST;
      cfg.boiler_setpoint    <= BOILER_SETPOINT_RST;
      cfg.diff_hyst          <= DIFF_HYST_RST;
      cfg.diff_threshold     <= DIFF_THRESHOLD_RST;
      cfg.instant_setpoint   <= INSTANT_SETPOINT_RST;
      cfg.instant_hyst       <= INSTANT_HYST_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PIPE_LIMIT:         cfg.pipe_limit         <= cfg_data[TEMP_W-1:0];
        REG_BOILER_UPPER_LIMIT: cfg.boiler_upper_limit <= cfg_data[TEMP_W-1:0];
        REG_BOILER_UPPER_HYST:  cfg.boiler_upper_hyst  <= cfg_data[HYST_W-1:0];
        REG_BOILER_SETPOINT:    cfg.boiler_setpoint    <= cfg_data[TEMP_W-1:0];
        REG_DIFF_HYST:          cfg.diff_hyst          <= cfg_data[HYST_W-1:0];
        REG_DIFF_THRESHOLD:     cfg.diff_threshold     <= cfg_data[TEMP_W-1:0];
        REG_INSTANT_SETPOINT:   cfg.instant_setpoint   <= cfg_data[TEMP_W-1:0];
        REG_INSTANT_HYST:       cfg.instant_hyst       <= cfg_data[HYST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/hdrc_relay_logic.sv
// ---------------------------------------------------------------------------
// hdrc_relay_logic
// One measurement period: error counting and both hysteresis relays.
// ---------------------------------------------------------------------------
module hdrc_relay_logic #(
  parameter logic [hdrc_pkg::LIMIT_W-1:0] ERROR_LIMIT = hdrc_pkg::ERROR_LIMIT_DEF
) (
  input  hdrc_pkg::cfg_t    cfg,
  input  hdrc_pkg::item_t   item,
  input  hdrc_pkg::state_t  st,
  output hdrc_pkg::state_t  st_next,
  output hdrc_pkg::result_t res
);
  import hdrc_pkg::*;

  logic                     over_limit;
  logic                     sensors_ok;
  logic signed [CALC_W-1:0] boiler;
  logic signed [CALC_W-1:0] pipe;
  logic signed [CALC_W-1:0] diff;
  logic signed [CALC_W-1:0] pipe_lim;
  logic signed [CALC_W-1:0] up_lim;
  logic signed [CALC_W-1:0] up_hyst;
  logic signed [CALC_W-1:0] setpt;
  logic signed [CALC_W-1:0] d_hyst;
  logic signed [CALC_W-1:0] d_thr;
  logic signed [CALC_W-1:0] i_setpt;
  logic signed [CALC_W-1:0] i_hyst;
  logic                     boiler_upd;
  logic                     instant_upd;

  // Operands widened so every sum and compare is exact
  always_comb begin
    boiler   = CALC_W'(item.boiler_temp);
    pipe     = CALC_W'(item.pipe_temp);
    diff     = pipe - boiler;
    pipe_lim = CALC_W'(cfg.pipe_limit);
    up_lim   = CALC_W'(cfg.boiler_upper_limit);
    up_hyst  = CALC_W'(cfg.boiler_upper_hyst);
    setpt    = CALC_W'(cfg.boiler_setpoint);
    d_hyst   = CALC_W'(cfg.diff_hyst);
    d_thr    = CALC_W'(cfg.diff_threshold);
    i_setpt  = CALC_W'(cfg.instant_setpoint);
    i_hyst   = CALC_W'(cfg.instant_hyst);
  end

  // Boiler relay: overheat protection above the pipe limit, else differential
  always_comb begin
    boiler_upd = st.boiler_on;
    if (pipe > pipe_lim) begin
      if (st.boiler_on) begin
        if (boiler > up_lim) boiler_upd = 1'b0;
      end else if (boiler + up_hyst < up_lim) begin
        boiler_upd = 1'b1;
      end
    end else begin
      if (st.boiler_on) begin
        if (boiler > setpt || diff + d_hyst < d_thr) boiler_upd = 1'b0;
      end else if (diff > d_thr && boiler + d_hyst < setpt) begin
        boiler_upd = 1'b1;
      end
    end
  end

  // Instant heater relay
  always_comb begin
    instant_upd = st.instant_on;
    if (st.instant_on) begin
      if (boiler > i_setpt) instant_upd = 1'b0;
    end else if (boiler + i_hyst < i_setpt) begin
      instant_upd = 1'b1;
    end
  end

  // Period outcome: reset request, bad sensor, or relay update
  always_comb begin
    over_limit = LIMIT_W'(st.error_count) > ERROR_LIMIT;
    sensors_ok = item.boiler_ok && item.pipe_ok;
    st_next    = st;
    res        = '0;
    if (over_limit) begin
      st_next           = '0;
      res.reset_request = 1'b1;
    end else if (!sensors_ok) begin
      if (st.error_count != ERR_CNT_MAX) st_next.error_count = st.error_count + 1'b1;
    end else begin
      st_next.error_count = '0;
      st_next.boiler_on   = boiler_upd;
      st_next.instant_on  = instant_upd;
      res.reading_valid   = 1'b1;
    end
    res.boiler_heat  = st_next.boiler_on;
    res.instant_heat = st_next.instant_on;
  end

endmodule

FILE: hdl/differential_heater_relay_control.sv
// ---------------------------------------------------------------------------
// differential_heater_relay_control
// Differential boiler thermostat with overheat protection and instant heater.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel takes one measurement period per request: boiler and pipe
//   temperatures in tdata, the two sensor-good flags in tuser.
//   m_* channel returns one result per request: relay states in tdata,
//   reading-valid and reset-request flags in tuser.
//   cfg_we/cfg_index/cfg_data write one register per cycle, only while idle;
//   the user must keep to that, the block does not enforce it. A request
//   waits in the input register, and the relay state updates once per request
//   as it moves to the result register when free. Throughput: one request per
//   cycle while m_tready is high; the two registers form a two-stage pipe.
//   When m_tready is low the result holds and one more request may wait in
//   the input register; s_tready then drops until the result is taken.
//   Reset (rst, synchronous) clears both relays, the error counter and both
//   valid flags, and loads the register defaults.
//   A period seen with the error counter above ERROR_LIMIT returns a reset
//   request with both relays off and clears the relay state.
// ---------------------------------------------------------------------------
module differential_heater_relay_control #(
  parameter logic [hdrc_pkg::LIMIT_W-1:0] ERROR_LIMIT = hdrc_pkg::ERROR_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [hdrc_pkg::S_TDATA_W-1:0]   s_tdata,   // boiler_temp[11:0], pipe_temp[23:12]
  input  logic [hdrc_pkg::S_TUSER_W-1:0]   s_tuser,   // boiler_ok[0], pipe_ok[1]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [hdrc_pkg::M_TDATA_W-1:0]   m_tdata,   // boiler_heat[0], instant_heat[1], zeros
  output logic [hdrc_pkg::M_TUSER_W-1:0]   m_tuser,   // reading_valid[0], reset_request[1]
  input  logic                             cfg_we,
  input  logic [hdrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdrc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hdrc_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  state_t  st;
  state_t  st_next;
  result_t res_next;
  result_t out_res;
  logic    out_valid;
  logic    advance;

  hdrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hdrc_relay_logic #(
    .ERROR_LIMIT (ERROR_LIMIT)
  ) u_logic (
    .cfg     (cfg),
    .item    (in_item),
    .st      (st),
    .st_next (st_next),
    .res     (res_next)
  );

  // Move the held request into the result register when it is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.boiler_temp <= s_tdata[TEMP_W-1:0];
      in_item.pipe_temp   <= s_tdata[2*TEMP_W-1:TEMP_W];
      in_item.boiler_ok   <= s_tuser[0];
      in_item.pipe_ok     <= s_tuser[1];
    end
  end

  // Relay and error-count state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, out_res.instant_heat, out_res.boiler_heat};
  assign m_tuser  = {out_res.reset_request, out_res.reading_valid};

endmodule

FILE: hdl/hdrc_checker.sv
// ---------------------------------------------------------------------------
// hdrc_checker
// Port-level checks on the result channel of the relay controller.
// ---------------------------------------------------------------------------
`include "differential_heater_relay_control_defines.svh"

module hdrc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [hdrc_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [hdrc_pkg::M_TUSER_W-1:0] m_tuser
);
  import hdrc_pkg::*;

  // A reset request carries both relays off and no valid reading
  `HDRC_ASSERT(a_rstreq_off, m_tvalid && m_tuser[1] |-> m_tdata[1:0] == 2'b00 && !m_tuser[0], "reset request with relay on or valid reading")

  // Padding bits above the relays stay zero
  `HDRC_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[M_TDATA_W-1:2] == '0, "nonzero padding in result")

  // A stalled result holds its contents
  `HDRC_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // No result right after reset
  `HDRC_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind differential_heater_relay_control hdrc_checker u_hdrc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
